// ===== rtl/cvl_pkg.sv =====
`timescale 1ns / 1ps

package cvl_pkg;

   localparam int CAPACITY = 16;
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int OUT_DATA_W = 8;

   typedef enum logic [0:0] {
      FUNC_APPEND = 1'b0,
      FUNC_DELETE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;   // latch the incoming operation
      logic execute;   // apply it to the list and load the response register
   } cmd_type;

endpackage

// ===== rtl/cvl_ctrl.sv =====
`timescale 1ns / 1ps

module cvl_ctrl
   import cvl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold the operation until the response register can take it
            if (rsp_free) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/cvl_datapath.sv =====
`timescale 1ns / 1ps

module cvl_datapath
   import cvl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  req_func,
   input  logic [VALUE_W-1:0]    req_value,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [COUNT_W-1:0]    rsp_count
);

   logic                 func_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [VALUE_W-1:0]   entries_ff [CAPACITY];
   logic [VALUE_W-1:0]   entries_in [CAPACITY];
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [CAPACITY-1:0]  hit;
   logic [CAPACITY-1:0]  shift_en;
   logic                 any_hit;
   logic                 full;

   assign full = (fill_ff >= FILL_W'(CAPACITY));

   // match only held entries; the prefix OR marks the first match and all above it
   always_comb begin
      logic acc;
      acc = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i]      = (FILL_W'(i) < fill_ff) && (entries_ff[i] == value_ff);
         acc         = acc | hit[i];
         shift_en[i] = acc;
      end
      any_hit = acc;
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
      end
      fill_in   = fill_ff;
      status_in = ST_DONE;
      if (func_ff == FUNC_APPEND) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (fill_ff == FILL_W'(i)) begin
                  entries_in[i] = value_ff;
               end
            end
            fill_in = fill_ff + 1'b1;
         end
      end else begin
         if (!any_hit) begin
            status_in = ST_NOT_FOUND;
         end else begin
            // close the gap: everything from the match upward moves down one place
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (shift_en[i]) begin
                  entries_in[i] = entries_ff[i+1];
               end
            end
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.execute) begin
         for (int i = 0; i < CAPACITY; i++) begin
            entries_ff[i] <= entries_in[i];
         end
         status_ff <= status_in;
         count_ff  <= COUNT_W'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.execute) begin
         fill_ff <= fill_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

endmodule

// ===== rtl/compacting_value_list.sv =====
`timescale 1ns / 1ps
// The request is captured, then the execute step applies it and loads the response
// register, which offers the response; a stalled response holds the execute step.
// A new request is accepted only once the previous one has been executed (capture, then
// compare and shift of the register array in a single execute step).
// Reset (synchronous, active high) empties the list and drops any pending response;
// entry contents are not cleared and are only ever read below the fill count.
module compacting_value_list
   import cvl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // [31:0] value
   input  logic                   req_tuser,   // [0] func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_DATA_W-1:0]  rsp_tdata,   // [4:0] count, [7:5] zero
   output logic [STATUS_W-1:0]    rsp_tuser    // [1:0] status
);

   cmd_type              cmd;
   logic [COUNT_W-1:0]   count;

   cvl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cvl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_func   (req_tuser),
      .req_value  (req_tdata),
      .rsp_status (rsp_tuser),
      .rsp_count  (count)
   );

   assign rsp_tdata = OUT_DATA_W'(count);

endmodule

// ===== tb/sv/cvl_list_checker.sv =====
`timescale 1ns / 1ps

module cvl_list_checker
   import cvl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,    // [31:0] value
   input  logic                  req_tuser,    // [0] func
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_DATA_W-1:0] rsp_tdata,    // [4:0] count, [7:5] zero
   input  logic [STATUS_W-1:0]   rsp_tuser,    // [1:0] status
   input  logic                  end_of_test,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct {
      status_type           status;
      logic [COUNT_W-1:0]   count;
   } list_reply_type;

   logic [VALUE_W-1:0] held_values [CAPACITY];
   int                 held_count;
   list_reply_type     expected_replies [$];
   bit                 wrapped_up;

   int n_appends, n_refused, n_deletes, n_missed, peak_fill;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Apply one operation to the shadow list and return the reply it should give.
   function automatic list_reply_type apply_list_op(input func_type op,
                                                    input logic [VALUE_W-1:0] v);
      list_reply_type r;
      int             hit;
      r.status = ST_DONE;
      hit      = -1;
      if (op == FUNC_APPEND) begin
         if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            held_values[held_count] = v;
            held_count++;
         end
      end else begin
         for (int i = 0; i < held_count; i++)
            if (hit < 0 && held_values[i] == v) hit = i;
         if (hit < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            // close the gap left by the removed entry
            for (int i = hit; i + 1 < held_count; i++)
               held_values[i] = held_values[i + 1];
            held_count--;
         end
      end
      r.count = held_count[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         held_count = 0;
         expected_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response status %0d count %0d with none expected",
                                         rsp_tuser, rsp_tdata[COUNT_W-1:0]));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tuser, want.status));
               if (rsp_tdata[COUNT_W-1:0] !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_tdata[COUNT_W-1:0], want.count));
               if (rsp_tdata[OUT_DATA_W-1:COUNT_W] !== '0)
                  report_mismatch($sformatf("padding bits of tdata %b, expected zero",
                                            rsp_tdata[OUT_DATA_W-1:COUNT_W]));
            end
         end

         if (req_tvalid && req_tready) begin
            want = apply_list_op(func_type'(req_tuser), req_tdata);
            expected_replies.push_back(want);
            if (func_type'(req_tuser) == FUNC_APPEND) begin
               n_appends++;
               if (want.status == ST_FULL) n_refused++;
            end else begin
               n_deletes++;
               if (want.status == ST_NOT_FOUND) n_missed++;
            end
            if (held_count > peak_fill) peak_fill = held_count;
         end

         if (end_of_test && !wrapped_up) begin
            wrapped_up = 1'b1;
            if (expected_replies.size() != 0) begin
               report_mismatch($sformatf("%0d responses never arrived",
                                         expected_replies.size()));
               expected_replies.delete();
            end
            $display("run covered %0d appends (%0d refused on a full list) and %0d deletes",
                     n_appends, n_refused, n_deletes);
            $display("  (%0d with no match); highest fill seen %0d of %0d",
                     n_missed, peak_fill, CAPACITY);
         end
      end
      outstanding = expected_replies.size();
   end

endmodule

// ===== tb/sv/tb_compacting_value_list.sv =====
`timescale 1ns / 1ps

module tb_compacting_value_list;
   import cvl_pkg::*;

   localparam int RANDOM_ITEMS = 900;
   localparam int LIMIT_CYCLES = 600000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  end_of_test;
   int                    fail_count;
   int                    outstanding;
   int                    cycles;
   bit                    calm;

   // values the list should hold, used to aim deletes at live entries and to tell when it is full
   logic [VALUE_W-1:0]    live_values [$];

   compacting_value_list u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cvl_list_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .end_of_test (end_of_test),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("[compacting_value_list] ERROR");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one; none during calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      // a narrow pool makes duplicates common
      if (r <= 3) return $urandom_range(0, 7);
      return $urandom();
   endfunction

   // Response side: random back-pressure at the falling edge.
   initial begin
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else begin
            rsp_tready = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) hold = pick_gap();
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer,
   // leaving tvalid high so back-to-back transfers need no extra step.
   task automatic issue_op(input func_type op, input logic [VALUE_W-1:0] v);
      int gap;
      int idx;
      gap = pick_gap();
      idx = -1;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (op == FUNC_APPEND) begin
         if (live_values.size() < CAPACITY) live_values.push_back(v);
      end else begin
         foreach (live_values[i])
            if (idx < 0 && live_values[i] == v) idx = i;
         if (idx >= 0) live_values.delete(idx);
      end
   endtask

   task automatic issue_delete_aimed();
      if (live_values.size() != 0 && $urandom_range(0, 9) < 7)
         issue_op(FUNC_DELETE, live_values[$urandom_range(0, live_values.size() - 1)]);
      else
         issue_op(FUNC_DELETE, pick_value());
   endtask

   initial begin
      int grow_pct;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_APPEND;
      end_of_test = 1'b0;
      calm        = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: delete on an empty list, then the extremes and a duplicate pair
      issue_op(FUNC_DELETE, 32'h0000_0000);
      issue_op(FUNC_APPEND, 32'h8000_0000);
      issue_op(FUNC_APPEND, 32'h7FFF_FFFF);
      issue_op(FUNC_APPEND, 32'h0000_0000);
      issue_op(FUNC_APPEND, 32'hFFFF_FFFF);
      issue_op(FUNC_APPEND, 32'h5555_5555);
      issue_op(FUNC_APPEND, 32'd7);
      issue_op(FUNC_APPEND, 32'd7);
      // only the lower of the two sevens goes; then a middle, the head, a miss
      issue_op(FUNC_DELETE, 32'd7);
      issue_op(FUNC_DELETE, 32'h0000_0000);
      issue_op(FUNC_DELETE, 32'h8000_0000);
      issue_op(FUNC_DELETE, 32'd99);
      // fill up, be refused, then remove the tail and the head of a full list
      while (live_values.size() < CAPACITY) issue_op(FUNC_APPEND, $urandom());
      issue_op(FUNC_APPEND, 32'hAAAA_AAAA);
      issue_op(FUNC_DELETE, live_values[$]);
      issue_op(FUNC_DELETE, live_values[0]);

      // random: alternate growing and shrinking phases so both ends are reached often
      grow_pct = 75;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            grow_pct = (grow_pct == 75) ? 25 : 75;
            calm     = ((n / 60) % 4 == 3);
         end
         if ($urandom_range(0, 99) < grow_pct)
            issue_op(FUNC_APPEND, pick_value());
         else
            issue_delete_aimed();
      end
      req_tvalid = 1'b0;
      calm       = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      end_of_test = 1'b1;
      repeat (2) @(negedge clock);

      if (fail_count == 0) begin
         $display("[compacting_value_list] OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[compacting_value_list] ERROR");
      end
      $finish;
   end

endmodule
